FILE: hdl/tpo_pkg.sv
package tpo_pkg;

   localparam int COORD_BITS   = 16;
   localparam int DIFF_BITS    = COORD_BITS + 1;
   localparam int PROD_BITS    = 2 * DIFF_BITS;
   localparam int SUM_BITS     = PROD_BITS + 1;
   localparam int CORNER_COUNT = 3;
   localparam int EDGE_STAGES  = 3;
   localparam int NUM_EDGES    = 2 * CORNER_COUNT;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_BITS-1:0]  diff_type;
   typedef logic signed [PROD_BITS-1:0]  prod_type;
   typedef logic signed [SUM_BITS-1:0]   sum_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } vertex_type;

endpackage

FILE: hdl/tpo_edge_test.sv
module tpo_edge_test (
   input  logic                clock,
   input  tpo_pkg::vertex_type p_vert,
   input  tpo_pkg::vertex_type q_vert,
   input  tpo_pkg::vertex_type t_vert [tpo_pkg::CORNER_COUNT],
   output logic                separates
);
   import tpo_pkg::*;

   // stage 1: edge normal and vertex offsets
   diff_type dx_in, dy_in, dx_ff, dy_ff;
   diff_type ox_in [CORNER_COUNT];
   diff_type oy_in [CORNER_COUNT];
   diff_type ox_ff [CORNER_COUNT];
   diff_type oy_ff [CORNER_COUNT];

   // stage 2: products
   prod_type px_in [CORNER_COUNT];
   prod_type py_in [CORNER_COUNT];
   prod_type px_ff [CORNER_COUNT];
   prod_type py_ff [CORNER_COUNT];

   // stage 3: projection sign
   sum_type                   proj [CORNER_COUNT];
   logic [CORNER_COUNT-1:0]   pos_in;
   logic [CORNER_COUNT-1:0]   pos_ff;

   always_comb begin
      dx_in = diff_type'(q_vert.y) - diff_type'(p_vert.y);
      dy_in = diff_type'(p_vert.x) - diff_type'(q_vert.x);
      for (int k = 0; k < CORNER_COUNT; k++) begin
         ox_in[k] = diff_type'(t_vert[k].x) - diff_type'(p_vert.x);
         oy_in[k] = diff_type'(t_vert[k].y) - diff_type'(p_vert.y);
      end
   end

   always_comb begin
      for (int k = 0; k < CORNER_COUNT; k++) begin
         px_in[k] = prod_type'(dx_ff) * prod_type'(ox_ff[k]);
         py_in[k] = prod_type'(dy_ff) * prod_type'(oy_ff[k]);
      end
   end

   always_comb begin
      for (int k = 0; k < CORNER_COUNT; k++) begin
         proj[k]   = sum_type'(px_ff[k]) + sum_type'(py_ff[k]);
         pos_in[k] = !proj[k][SUM_BITS-1] && (proj[k] != '0);
      end
   end

   always_ff @(posedge clock) begin
      dx_ff <= dx_in;
      dy_ff <= dy_in;
      for (int k = 0; k < CORNER_COUNT; k++) begin
         ox_ff[k] <= ox_in[k];
         oy_ff[k] <= oy_in[k];
         px_ff[k] <= px_in[k];
         py_ff[k] <= py_in[k];
      end
      pos_ff <= pos_in;
   end

   assign separates = &pos_ff;

endmodule

FILE: hdl/triangle_pair_overlap_2d_top.sv
// Triangle pair overlap test in the plane, separating axis method.
//
// Request channel: present both triangles on the req_ ports and raise start.
// A beat is taken at every rising edge where start is high and busy is low.
// busy never rises, so a new pair may be offered in every cycle.
//
// Response channel: rsp_valid is high for one cycle with rsp_overlap, which
// is 1 when the triangles intersect or touch and 0 when some edge of either
// triangle separates them. Results leave in request order.
//
// Throughput: one pair per cycle. An accepted pair passes four register stages
// (offsets, products, projection signs, edge reduction) before rsp_valid rises;
// the 36 multipliers run in parallel, one per projection term.
//
// Reset: synchronous, clears all valid bits so no beat in flight is reported.
// The receiver cannot stall; every response is taken in the cycle it shows.
module triangle_pair_overlap_2d_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  tpo_pkg::coord_type  req_a_x0,
   input  tpo_pkg::coord_type  req_a_y0,
   input  tpo_pkg::coord_type  req_a_x1,
   input  tpo_pkg::coord_type  req_a_y1,
   input  tpo_pkg::coord_type  req_a_x2,
   input  tpo_pkg::coord_type  req_a_y2,
   input  tpo_pkg::coord_type  req_b_x0,
   input  tpo_pkg::coord_type  req_b_y0,
   input  tpo_pkg::coord_type  req_b_x1,
   input  tpo_pkg::coord_type  req_b_y1,
   input  tpo_pkg::coord_type  req_b_x2,
   input  tpo_pkg::coord_type  req_b_y2,
   output logic                rsp_valid,
   output logic                rsp_overlap
);
   import tpo_pkg::*;

   vertex_type a_vert [CORNER_COUNT];
   vertex_type b_vert [CORNER_COUNT];

   logic [NUM_EDGES-1:0]   edge_sep;
   logic [EDGE_STAGES-1:0] vld_in, vld_ff;
   logic                   rsp_valid_in, rsp_valid_ff;
   logic                   rsp_overlap_in, rsp_overlap_ff;
   logic                   accept;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign a_vert[0] = '{x: req_a_x0, y: req_a_y0};
   assign a_vert[1] = '{x: req_a_x1, y: req_a_y1};
   assign a_vert[2] = '{x: req_a_x2, y: req_a_y2};
   assign b_vert[0] = '{x: req_b_x0, y: req_b_y0};
   assign b_vert[1] = '{x: req_b_x1, y: req_b_y1};
   assign b_vert[2] = '{x: req_b_x2, y: req_b_y2};

   // edges run from the previous vertex to the current one
   for (genvar e = 0; e < CORNER_COUNT; e++) begin : g_edge
      tpo_edge_test u_a_edge (
         .clock     (clock),
         .p_vert    (a_vert[(e + CORNER_COUNT - 1) % CORNER_COUNT]),
         .q_vert    (a_vert[e]),
         .t_vert    (b_vert),
         .separates (edge_sep[e])
      );

      tpo_edge_test u_b_edge (
         .clock     (clock),
         .p_vert    (b_vert[(e + CORNER_COUNT - 1) % CORNER_COUNT]),
         .q_vert    (b_vert[e]),
         .t_vert    (a_vert),
         .separates (edge_sep[CORNER_COUNT+e])
      );
   end

   always_comb begin
      vld_in         = {vld_ff[EDGE_STAGES-2:0], accept};
      rsp_valid_in   = vld_ff[EDGE_STAGES-1];
      rsp_overlap_in = !(|edge_sep);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_overlap_ff <= rsp_overlap_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_overlap = rsp_overlap_ff;

   // every accepted beat gives a response once it has passed the pipeline
   a_accept_to_rsp : assert property (
      @(posedge clock) disable iff (reset)
      accept |-> ##4 rsp_valid
   ) else $error("accepted beat produced no response");

   // no response without a matching accepted beat
   a_rsp_from_accept : assert property (
      @(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 4)
   ) else $error("response without accepted beat");

   // a triangle always overlaps its own copy
   a_self_overlap : assert property (
      @(posedge clock) disable iff (reset)
      (accept && a_vert[0] == b_vert[0] && a_vert[1] == b_vert[1] &&
       a_vert[2] == b_vert[2]) |-> ##4 rsp_overlap
   ) else $error("identical triangles reported apart");

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
   import tpo_pkg::*;

   typedef struct packed {
      vertex_type [2:0] a;
      vertex_type [2:0] b;
   } tri_pair_type;

   localparam int DIRECTED_PAIRS = 20;
   localparam int RANDOM_PAIRS   = 1850;
   localparam int TAIL_CYCLES    = 8;
   localparam int STALL_LIMIT    = 1000;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      start = 1'b0;
   logic      busy;
   coord_type req_a_x0 = '0;
   coord_type req_a_y0 = '0;
   coord_type req_a_x1 = '0;
   coord_type req_a_y1 = '0;
   coord_type req_a_x2 = '0;
   coord_type req_a_y2 = '0;
   coord_type req_b_x0 = '0;
   coord_type req_b_y0 = '0;
   coord_type req_b_x1 = '0;
   coord_type req_b_y1 = '0;
   coord_type req_b_x2 = '0;
   coord_type req_b_y2 = '0;
   logic      rsp_valid;
   logic      rsp_overlap;

   tri_pair_type pending_pairs[$];
   bit           overlap_due[$];
   tri_pair_type cur_pair;
   bit           took;
   int           burst_left = 1;
   int           gap_left = 0;
   int           mismatches = 0;
   int           n_overlap = 0;
   int           n_apart = 0;
   int           idle_cycles = 0;

   triangle_pair_overlap_2d_top u_top (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_a_x0    (req_a_x0),
      .req_a_y0    (req_a_y0),
      .req_a_x1    (req_a_x1),
      .req_a_y1    (req_a_y1),
      .req_a_x2    (req_a_x2),
      .req_a_y2    (req_a_y2),
      .req_b_x0    (req_b_x0),
      .req_b_y0    (req_b_y0),
      .req_b_x1    (req_b_x1),
      .req_b_y1    (req_b_y1),
      .req_b_x2    (req_b_x2),
      .req_b_y2    (req_b_y2),
      .rsp_valid   (rsp_valid),
      .rsp_overlap (rsp_overlap)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // true when every vertex of t lies strictly on the outer side of edge p->q
   function automatic bit edge_separates(vertex_type p, vertex_type q, vertex_type [2:0] t);
      longint dx;
      longint dy;
      longint proj;
      dx = longint'(q.y) - longint'(p.y);
      dy = longint'(p.x) - longint'(q.x);
      for (int k = 0; k < 3; k++) begin
         proj = dx * (longint'(t[k].x) - longint'(p.x)) + dy * (longint'(t[k].y) - longint'(p.y));
         if (proj <= 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic bit tri_separates(vertex_type [2:0] e, vertex_type [2:0] t);
      for (int c = 0; c < 3; c++) begin
         if (edge_separates(e[(c + 2) % 3], e[c], t)) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic bit overlap_of(tri_pair_type p);
      return !(tri_separates(p.a, p.b) || tri_separates(p.b, p.a));
   endfunction

   function automatic coord_type sat_coord(int v);
      if (v > 32767) return coord_type'(32767);
      if (v < -32768) return coord_type'(-32768);
      return coord_type'(v);
   endfunction

   function automatic vertex_type near_point(int cx, int cy, int r);
      vertex_type v;
      v.x = sat_coord(cx + int'($urandom_range(0, 2 * r)) - r);
      v.y = sat_coord(cy + int'($urandom_range(0, 2 * r)) - r);
      return v;
   endfunction

   function automatic vertex_type [2:0] make_ccw(vertex_type [2:0] t);
      longint turn;
      vertex_type tmp;
      turn = (longint'(t[1].x) - t[0].x) * (longint'(t[2].y) - t[0].y)
           - (longint'(t[1].y) - t[0].y) * (longint'(t[2].x) - t[0].x);
      if (turn < 0) begin
         tmp  = t[1];
         t[1] = t[2];
         t[2] = tmp;
      end
      return t;
   endfunction

   function automatic coord_type edge_value();
      case ($urandom_range(0, 5))
         0: return coord_type'(-32768);
         1: return coord_type'(32767);
         2: return coord_type'(0);
         3: return coord_type'(-1);
         4: return coord_type'(1);
         default: return coord_type'($urandom);
      endcase
   endfunction

   function automatic tri_pair_type pair_of(int v[12]);
      tri_pair_type p;
      for (int k = 0; k < 3; k++) begin
         p.a[k].x = coord_type'(v[2 * k]);
         p.a[k].y = coord_type'(v[2 * k + 1]);
         p.b[k].x = coord_type'(v[6 + 2 * k]);
         p.b[k].y = coord_type'(v[6 + 2 * k + 1]);
      end
      return p;
   endfunction

   function automatic tri_pair_type random_pair();
      tri_pair_type p;
      int kind;
      int cx;
      int cy;
      int r;
      int j;
      int k;
      kind = $urandom_range(0, 9);
      if (kind <= 1) begin
         p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      end else if (kind == 8) begin
         for (k = 0; k < 3; k++) begin
            p.a[k].x = edge_value();
            p.a[k].y = edge_value();
            p.b[k].x = edge_value();
            p.b[k].y = edge_value();
         end
      end else begin
         // clustered pairs so near misses and contact show up often
         cx = int'($urandom_range(0, 65535)) - 32768;
         cy = int'($urandom_range(0, 65535)) - 32768;
         r  = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 4000))
                                           : int'($urandom_range(1, 64));
         for (k = 0; k < 3; k++) p.a[k] = near_point(cx, cy, r);
         cx = cx + int'($urandom_range(0, 4 * r)) - 2 * r;
         cy = cy + int'($urandom_range(0, 4 * r)) - 2 * r;
         for (k = 0; k < 3; k++) p.b[k] = near_point(cx, cy, r);
         if (kind == 6 || kind == 7) begin
            j = $urandom_range(0, 2);
            k = $urandom_range(0, 2);
            p.b[j] = p.a[k];
            if ($urandom_range(0, 1)) p.b[(j + 1) % 3] = p.a[(k + 2) % 3];
         end else if (kind == 9) begin
            p.a[1] = p.a[0];
            if ($urandom_range(0, 1)) p.a[2] = p.a[0];
            if ($urandom_range(0, 1)) p.b[2] = p.b[1];
         end
      end
      if ($urandom_range(0, 3) != 0) begin
         p.a = make_ccw(p.a);
         p.b = make_ccw(p.b);
      end
      return p;
   endfunction

   // driver: bursts of beats with random gaps
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || took) begin
         if (gap_left > 0) begin
            gap_left = gap_left - 1;
            start <= 1'b0;
         end else if (pending_pairs.size() > 0) begin
            cur_pair = pending_pairs.pop_front();
            req_a_x0 <= cur_pair.a[0].x;
            req_a_y0 <= cur_pair.a[0].y;
            req_a_x1 <= cur_pair.a[1].x;
            req_a_y1 <= cur_pair.a[1].y;
            req_a_x2 <= cur_pair.a[2].x;
            req_a_y2 <= cur_pair.a[2].y;
            req_b_x0 <= cur_pair.b[0].x;
            req_b_y0 <= cur_pair.b[0].y;
            req_b_x1 <= cur_pair.b[1].x;
            req_b_y1 <= cur_pair.b[1].y;
            req_b_x2 <= cur_pair.b[2].x;
            req_b_y2 <= cur_pair.b[2].y;
            start <= 1'b1;
            burst_left = burst_left - 1;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: check results, then record the beat taken at this edge
   always @(posedge clock) begin
      bit want;
      if (!reset && rsp_valid) begin
         if (overlap_due.size() == 0) begin
            $error("unexpected result: overlap %b with nothing pending", rsp_overlap);
            mismatches++;
         end else begin
            want = overlap_due.pop_front();
            if (rsp_overlap !== want) begin
               $error("overlap: expected %b, actual %b", want, rsp_overlap);
               mismatches++;
            end
            if (want) n_overlap++;
            else n_apart++;
         end
      end
      took = !reset && start && !busy;
      if (took) overlap_due = {overlap_due, overlap_of(cur_pair)};
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("watchdog: %0d cycles without progress, %0d results outstanding",
                  idle_cycles, overlap_due.size());
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      // degenerate points, identical and shared-edge triangles
      pending_pairs = {pending_pairs, pair_of('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0})};
      pending_pairs = {pending_pairs, pair_of('{0, 0, 256, 0, 0, 256, 0, 0, 256, 0, 0, 256})};
      pending_pairs = {pending_pairs,
                       pair_of('{0, 0, 256, 0, 0, 256, 256, 0, 256, 256, 0, 256})};
      // shared vertex only, then one unit apart, a near miss and a point contact on the hypotenuse
      pending_pairs = {pending_pairs,
                       pair_of('{0, 0, 256, 0, 0, 256, 256, 0, 512, 0, 256, 256})};
      pending_pairs = {pending_pairs,
                       pair_of('{0, 0, 256, 0, 0, 256, 257, 0, 513, 0, 257, 256})};
      pending_pairs = {pending_pairs,
                       pair_of('{0, 0, 256, 0, 0, 256, 129, 128, 385, 128, 129, 384})};
      pending_pairs = {pending_pairs,
                       pair_of('{0, 0, 256, 0, 0, 256, 128, 128, 384, 128, 128, 384})};
      // small triangle inside a large one
      pending_pairs = {pending_pairs, pair_of('{-4096, -4096, 4096, -4096, 0, 4096,
                                                 -16, -16, 16, -16, 0, 16})};
      // clockwise winding
      pending_pairs = {pending_pairs,
                       pair_of('{0, 0, 0, 256, 256, 0, 512, 512, 768, 512, 512, 768})};
      pending_pairs = {pending_pairs,
                       pair_of('{0, 0, 0, 256, 256, 0, 64, 64, 128, 64, 64, 128})};
      // zero-length edges: point and segment
      pending_pairs = {pending_pairs,
                       pair_of('{100, 100, 100, 100, 100, 100, 0, 0, 256, 0, 0, 256})};
      pending_pairs = {pending_pairs,
                       pair_of('{900, 900, 900, 900, 900, 900, 0, 0, 256, 0, 0, 256})};
      pending_pairs = {pending_pairs,
                       pair_of('{0, 0, 0, 0, 256, 256, 256, 0, 512, 0, 256, 256})};
      pending_pairs = {pending_pairs,
                       pair_of('{-512, 0, -512, 0, -256, 256, 0, 0, 256, 0, 0, 256})};
      // coordinate extremes
      pending_pairs = {pending_pairs, pair_of('{-32768, -32768, 32767, -32768, -32768, 32767,
                                                 32767, 32767, 32767, 32767, 32767, 32767})};
      pending_pairs = {pending_pairs, pair_of('{-32768, -32768, 32767, -32768, -32768, 32767,
                                                 32767, 32767, -32768, 32767, 32767, -32768})};
      pending_pairs = {pending_pairs, pair_of('{-32768, -32768, -32767, -32768, -32768, -32767,
                                                 32767, 32767, 32766, 32767, 32767, 32766})};
      pending_pairs = {pending_pairs, pair_of('{-1, -1, -1, -1, -1, -1, 0, 0, 0, 0, 0, 0})};
      pending_pairs = {pending_pairs, pair_of('{21845, -21846, -21846, 21845, 21845, 21845,
                                                 -21846, -21846, 21845, -21846, -21846, 21845})};
      pending_pairs = {pending_pairs, pair_of('{32767, -32768, 32767, 32767, -32768, 32767,
                                                 -32768, -32768, 32767, -32768, -32768, 32767})};
      for (int n = 0; n < RANDOM_PAIRS; n++) pending_pairs = {pending_pairs, random_pair()};

      repeat (3) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      while (pending_pairs.size() > 0 || start || overlap_due.size() > 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("%0d triangle pairs checked (%0d directed, %0d random)",
               n_overlap + n_apart, DIRECTED_PAIRS, RANDOM_PAIRS);
      $display("results: %0d overlapping or touching, %0d separated", n_overlap, n_apart);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hdl/tpo_pkg.sv
hdl/tpo_edge_test.sv
hdl/triangle_pair_overlap_2d_top.sv
tb/sv/tb.sv
